// ----- design/tcs_pkg.sv -----
// Shared types and constants of the text console scrollback unit.
// Used by the front end, the back end and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

  // Action codes on the input port.
  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_ERASE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Operations after the front end has classified a word.
  typedef enum logic [2:0] {
    OP_PRINT   = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_TAB     = 3'd2,
    OP_BKSP    = 3'd3,
    OP_ERASE   = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_READ    = 3'd6
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e         op;
    logic [15:0] char_cell;
    logic [4:0]  view_row;
    logic [6:0]  view_col;
    logic        view_ok;
  } cmd_t;

  localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_BKSP     = 8'h08;
  localparam logic [15:0] BLANK_RESET = 16'h0F00;

endpackage

`default_nettype wire

// ----- design/tcs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/tcs_front.sv -----
// Front end: accepts input words, classifies them into commands and holds
// them in a two-entry queue for the back end. Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcs_front #(
  parameter int COLUMNS      = 80,
  parameter int VISIBLE_ROWS = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       action_i,
  input  wire logic [15:0]      char_cell_i,
  input  wire logic [4:0]       view_row_i,
  input  wire logic [6:0]       view_col_i,
  output logic                  busy_o,
  output logic                  cmd_valid_o,
  output tcs_pkg::cmd_t         cmd_o,
  input  wire logic             cmd_pop_i
);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  tcs_pkg::cmd_t  q_mem_q [QDEPTH];
  tcs_pkg::cmd_t  cmd_new;
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_new.char_cell = char_cell_i;
    cmd_new.view_row  = view_row_i;
    cmd_new.view_col  = view_col_i;
    cmd_new.view_ok   = (32'(view_row_i) < VISIBLE_ROWS) && (32'(view_col_i) < COLUMNS);
    case (tcs_pkg::action_e'(action_i))
      tcs_pkg::ACT_PUT: begin
        case (char_cell_i[7:0])
          tcs_pkg::CH_NEWLINE: cmd_new.op = tcs_pkg::OP_NEWLINE;
          tcs_pkg::CH_TAB:     cmd_new.op = tcs_pkg::OP_TAB;
          tcs_pkg::CH_BKSP:    cmd_new.op = tcs_pkg::OP_BKSP;
          default:             cmd_new.op = tcs_pkg::OP_PRINT;
        endcase
      end
      tcs_pkg::ACT_ERASE: cmd_new.op = tcs_pkg::OP_ERASE;
      tcs_pkg::ACT_CLEAR: cmd_new.op = tcs_pkg::OP_CLEAR;
      tcs_pkg::ACT_READ:  cmd_new.op = tcs_pkg::OP_READ;
      default:            cmd_new.op = tcs_pkg::OP_READ;
    endcase
  end

  assign busy_o      = (count_q == QCW'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // The queue depth is a power of two, so the pointers wrap on their own.
  assign wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
  assign rd_ptr_d = pop  ? rd_ptr_q + QAW'(1) : rd_ptr_q;
  assign count_d  = count_q + QCW'(push) - QCW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcs_back.sv -----
// Back end: executes queued commands against the cursor state and the
// scrollback store, and emits one result per command. Depends on tcs_pkg, tcs_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcs_back #(
  parameter int COLUMNS      = 80,
  parameter int STORE_ROWS   = 100,
  parameter int VISIBLE_ROWS = 25,
  parameter int TAB_STOP     = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [15:0]   blank_cell_i,
  input  wire logic          cmd_valid_i,
  input  wire tcs_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               done_o,
  output logic [4:0]         cursor_row_o,
  output logic [6:0]         cursor_col_o,
  output logic [6:0]         window_top_o,
  output logic [15:0]        read_cell_o
);

  localparam int LW       = $clog2(STORE_ROWS);
  localparam int FW       = $clog2(STORE_ROWS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int PW       = $clog2(TAB_STOP + 1);
  localparam int DEPTH    = STORE_ROWS * COLUMNS;
  localparam int AW       = $clog2(DEPTH);
  localparam int WIN_OFF  = VISIBLE_ROWS - 1;

  localparam logic [LW-1:0] LAST_ROW = LW'(STORE_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PH_TOP   = PW'(TAB_STOP - 1);
  localparam logic [PW-1:0] LAST_PH  = PW'((COLUMNS - 1) % TAB_STOP);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_ROW   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CELL  = 8'b0001_0000,
    S_RDATA = 8'b0010_0000,
    S_SWEEP = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] line_q, line_d;
  logic [CW-1:0] col_q, col_d;
  logic [PW-1:0] ph_q, ph_d;
  logic [LW-1:0] base_q, base_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   clr_blank_q, clr_blank_d;
  logic          sweep_q, sweep_d;
  logic          scroll_q, scroll_d;

  tcs_pkg::cmd_t cmd_q, cmd_d;
  logic [LW-1:0] acc_row_q, acc_row_d;
  logic [CW-1:0] acc_col_q, acc_col_d;
  logic [15:0]   wdata_q, wdata_d;
  logic [LW-1:0] phys_q, phys_d;
  logic [AW-1:0] row_addr_q, row_addr_d;
  logic [CW-1:0] sweep_col_q, sweep_col_d;
  logic [15:0]   sweep_val_q, sweep_val_d;
  logic [15:0]   rd_q, rd_d;

  logic [LW-1:0] top;
  logic [LW:0]   read_row;
  logic [LW:0]   row_sum;
  logic [CW:0]   tab_col;
  logic          do_nl;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  // The window ends at the cursor row, but never starts above row 0.
  assign top      = (32'(line_q) >= WIN_OFF) ? line_q - LW'(WIN_OFF) : '0;
  assign read_row = (LW+1)'(top) + (LW+1)'(cmd_q.view_row);
  assign row_sum  = (LW+1)'(base_q) + (LW+1)'(acc_row_q);
  assign tab_col  = (CW+1)'(col_q) + (CW+1)'(TAB_STOP) - (CW+1)'(ph_q);

  assign ram_addr  = row_addr_q + AW'(sweep_q ? sweep_col_q : acc_col_q);
  assign ram_wdata = sweep_q ? sweep_val_q : wdata_q;

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    col_d       = col_q;
    ph_d        = ph_q;
    base_d      = base_q;
    fill_d      = fill_q;
    clr_blank_d = clr_blank_q;
    sweep_d     = sweep_q;
    scroll_d    = scroll_q;
    cmd_d       = cmd_q;
    acc_row_d   = acc_row_q;
    acc_col_d   = acc_col_q;
    wdata_d     = wdata_q;
    phys_d      = phys_q;
    row_addr_d  = row_addr_q;
    sweep_col_d = sweep_col_q;
    sweep_val_d = sweep_val_q;
    rd_d        = rd_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    do_nl       = 1'b0;

    case (state_q)
      S_IDLE: begin
        // Rows at or past the fill count hold the blank of the last clear.
        // The cursor row is always made real before the next command runs.
        if (FW'(line_q) >= fill_q) begin
          acc_row_d   = LW'(fill_q);
          sweep_d     = 1'b1;
          scroll_d    = 1'b0;
          sweep_val_d = clr_blank_q;
          sweep_col_d = '0;
          state_d     = S_ROW;
        end else if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_d    = '0;
        sweep_d = 1'b0;
        state_d = S_DONE;
        case (cmd_q.op)
          tcs_pkg::OP_PRINT: begin
            acc_row_d = line_q;
            acc_col_d = col_q;
            wdata_d   = cmd_q.char_cell;
            state_d   = S_ROW;
          end
          tcs_pkg::OP_NEWLINE: begin
            do_nl = 1'b1;
          end
          tcs_pkg::OP_TAB: begin
            if (32'(tab_col) >= COLUMNS) begin
              do_nl = 1'b1;
            end else begin
              col_d = CW'(tab_col);
              ph_d  = '0;
            end
          end
          tcs_pkg::OP_BKSP: begin
            if (col_q != '0) begin
              col_d = col_q - CW'(1);
              ph_d  = (ph_q == '0) ? PH_TOP : ph_q - PW'(1);
            end
          end
          tcs_pkg::OP_ERASE: begin
            if (col_q != '0) begin
              col_d     = col_q - CW'(1);
              ph_d      = (ph_q == '0) ? PH_TOP : ph_q - PW'(1);
              acc_row_d = line_q;
              acc_col_d = col_q - CW'(1);
            end else if (line_q != '0) begin
              line_d    = line_q - LW'(1);
              col_d     = LAST_COL;
              ph_d      = LAST_PH;
              acc_row_d = line_q - LW'(1);
              acc_col_d = LAST_COL;
            end else begin
              acc_row_d = '0;
              acc_col_d = '0;
            end
            wdata_d = blank_cell_i;
            state_d = S_ROW;
          end
          tcs_pkg::OP_CLEAR: begin
            clr_blank_d = blank_cell_i;
            fill_d      = '0;
            base_d      = '0;
            line_d      = '0;
            col_d       = '0;
            ph_d        = '0;
          end
          tcs_pkg::OP_READ: begin
            if (cmd_q.view_ok && (32'(read_row) < STORE_ROWS)) begin
              if (read_row >= (LW+1)'(fill_q)) begin
                rd_d = clr_blank_q;
              end else begin
                acc_row_d = LW'(read_row);
                acc_col_d = CW'(cmd_q.view_col);
                state_d   = S_ROW;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ROW: begin
        // Logical rows sit in a ring that starts at base_q.
        phys_d  = (32'(row_sum) >= STORE_ROWS) ? LW'(row_sum - (LW+1)'(STORE_ROWS))
                                               : LW'(row_sum);
        state_d = S_MUL;
      end
      S_MUL: begin
        row_addr_d = AW'(phys_q) * AW'(COLUMNS);
        state_d    = sweep_q ? S_SWEEP : S_CELL;
      end
      S_CELL: begin
        state_d = S_DONE;
        if (cmd_q.op == tcs_pkg::OP_READ) begin
          ram_re  = 1'b1;
          state_d = S_RDATA;
        end else begin
          ram_we = 1'b1;
          if (cmd_q.op == tcs_pkg::OP_PRINT) begin
            if (col_q == LAST_COL) begin
              do_nl = 1'b1;
            end else begin
              col_d = col_q + CW'(1);
              ph_d  = (ph_q == PH_TOP) ? '0 : ph_q + PW'(1);
            end
          end
        end
      end
      S_RDATA: begin
        rd_d    = ram_rdata;
        state_d = S_DONE;
      end
      S_SWEEP: begin
        ram_we      = 1'b1;
        sweep_col_d = sweep_col_q + CW'(1);
        if (sweep_col_q == LAST_COL) begin
          sweep_d = 1'b0;
          if (scroll_q) begin
            state_d = S_DONE;
          end else begin
            fill_d  = fill_q + FW'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // Next line; past the last row the ring turns by one and the new
    // bottom row is blanked with the current blank cell.
    if (do_nl) begin
      col_d = '0;
      ph_d  = '0;
      if (line_q == LAST_ROW) begin
        base_d      = (base_q == LAST_ROW) ? '0 : base_q + LW'(1);
        acc_row_d   = LAST_ROW;
        sweep_d     = 1'b1;
        scroll_d    = 1'b1;
        sweep_val_d = blank_cell_i;
        sweep_col_d = '0;
        state_d     = S_ROW;
      end else begin
        line_d  = line_q + LW'(1);
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      line_q      <= '0;
      col_q       <= '0;
      ph_q        <= '0;
      base_q      <= '0;
      fill_q      <= '0;
      clr_blank_q <= tcs_pkg::BLANK_RESET;
      sweep_q     <= 1'b0;
      scroll_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      col_q       <= col_d;
      ph_q        <= ph_d;
      base_q      <= base_d;
      fill_q      <= fill_d;
      clr_blank_q <= clr_blank_d;
      sweep_q     <= sweep_d;
      scroll_q    <= scroll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    acc_row_q   <= acc_row_d;
    acc_col_q   <= acc_col_d;
    wdata_q     <= wdata_d;
    phys_q      <= phys_d;
    row_addr_q  <= row_addr_d;
    sweep_col_q <= sweep_col_d;
    sweep_val_q <= sweep_val_d;
    rd_q        <= rd_d;
  end

  tcs_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o       = (state_q == S_DONE);
  assign cursor_row_o = 5'(line_q - top);
  assign cursor_col_o = 7'(col_q);
  assign window_top_o = 7'(top);
  assign read_cell_o  = rd_q;

endmodule

`default_nettype wire

// ----- design/text_console_scrollback_unit.sv -----
// Top level of the text console scrollback unit: blank cell register,
// front end with command queue, back end with the store. Depends on tcs_pkg,
// tcs_front, tcs_back.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken at a clock edge with start high and busy low; every word
// gives exactly one result, shown for one cycle with done_o high, in order.
// The receiver cannot stall, and two words can wait in the command queue
// while the back end works. Passing the last store row adds a blanking
// sweep of the new bottom row, and the first time the cursor enters a row
// after reset or clear that row is filled with the blank cell of the last
// clear (after reset, the reset blank cell) before the next word starts;
// after reset this pass runs once for row 0. These sweeps go one cell per
// cycle through the single store port.
module text_console_scrollback_unit #(
  parameter int COLUMNS      = 80,
  parameter int STORE_ROWS   = 100,
  parameter int VISIBLE_ROWS = 25,
  parameter int TAB_STOP     = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] char_cell_i,
  input  wire logic [4:0]  view_row_i,
  input  wire logic [6:0]  view_col_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             done_o,
  output logic [4:0]       cursor_row_o,
  output logic [6:0]       cursor_col_o,
  output logic [6:0]       window_top_o,
  output logic [15:0]      read_cell_o
);

  logic [15:0]   blank_cell_q, blank_cell_d;
  logic          cmd_valid;
  logic          cmd_pop;
  tcs_pkg::cmd_t cmd;

  assign blank_cell_d = cfg_we_i ? cfg_wdata_i : blank_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_cell_q <= tcs_pkg::BLANK_RESET;
    end else begin
      blank_cell_q <= blank_cell_d;
    end
  end

  tcs_front #(
    .COLUMNS      (COLUMNS),
    .VISIBLE_ROWS (VISIBLE_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_i),
    .char_cell_i (char_cell_i),
    .view_row_i  (view_row_i),
    .view_col_i  (view_col_i),
    .busy_o      (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tcs_back #(
    .COLUMNS      (COLUMNS),
    .STORE_ROWS   (STORE_ROWS),
    .VISIBLE_ROWS (VISIBLE_ROWS),
    .TAB_STOP     (TAB_STOP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blank_cell_i (blank_cell_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .done_o       (done_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .window_top_o (window_top_o),
    .read_cell_o  (read_cell_o)
  );

`ifndef NO_ASSERTIONS
  // A result is never followed by another in the next cycle.
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // The cursor always lies inside the visible window.
  a_cursor_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(cursor_row_o) < VISIBLE_ROWS))
    else $error("cursor row outside the window");

  a_cursor_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(cursor_col_o) < COLUMNS))
    else $error("cursor column outside the line");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_text_console_scrollback_unit.sv -----
// Self-checking testbench of the text console scrollback unit: directed and
// random words, a scoreboard class that tracks the console and its store.
// Depends on tcs_pkg and text_console_scrollback_unit.
`timescale 1ns / 1ps

module tb_text_console_scrollback_unit;

  localparam int COLUMNS      = 80;
  localparam int STORE_ROWS   = 100;
  localparam int VISIBLE_ROWS = 25;
  localparam int TAB_STOP     = 4;
  localparam int STORE_CELLS  = COLUMNS * STORE_ROWS;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 5;
  localparam int PHASE_WORDS  = 325;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [6:0]  window_top;
    logic [15:0] read_cell;
  } console_status_t;

  class console_tracker;
    logic [15:0]     blank;
    int unsigned     line;
    int unsigned     col;
    logic [15:0]     cells [STORE_CELLS];
    console_status_t pending_status [$];
    int              mismatches;
    int              results;
    int              scrolls;
    int unsigned     deepest_line;

    function new();
      blank = tcs_pkg::BLANK_RESET;
      line = 0;
      col = 0;
      mismatches = 0;
      results = 0;
      scrolls = 0;
      deepest_line = 0;
      foreach (cells[i]) cells[i] = tcs_pkg::BLANK_RESET;
    endfunction

    task flag(string what);
      mismatches++;
      $display("%0t ns: %s", $realtime, what);
    endtask

    function void next_line();
      col = 0;
      if (line + 1 >= STORE_ROWS) begin
        line = STORE_ROWS - 1;
        for (int i = 0; i < (STORE_ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int c = 0; c < COLUMNS; c++) cells[(STORE_ROWS - 1) * COLUMNS + c] = blank;
        scrolls++;
      end else begin
        line++;
      end
      if (line > deepest_line) deepest_line = line;
    endfunction

    // Works out the status that an accepted word must produce.
    function void note_word(tcs_pkg::action_e act, logic [15:0] char_cell,
                            logic [4:0] vrow, logic [6:0] vcol);
      int unsigned     top;
      int unsigned     stop;
      console_status_t st;
      case (act)
        tcs_pkg::ACT_PUT: begin
          if (char_cell[7:0] == tcs_pkg::CH_NEWLINE) begin
            next_line();
          end else if (char_cell[7:0] == tcs_pkg::CH_TAB) begin
            stop = (col / TAB_STOP + 1) * TAB_STOP;
            if (stop >= COLUMNS) next_line();
            else col = stop;
          end else if (char_cell[7:0] == tcs_pkg::CH_BKSP) begin
            if (col > 0) col--;
          end else begin
            cells[line * COLUMNS + col] = char_cell;
            col++;
            if (col >= COLUMNS) next_line();
          end
        end
        tcs_pkg::ACT_ERASE: begin
          if (col > 0) begin
            col--;
          end else if (line > 0) begin
            line--;
            col = COLUMNS - 1;
          end
          cells[line * COLUMNS + col] = blank;
        end
        tcs_pkg::ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = blank;
          line = 0;
          col = 0;
        end
        default: ;
      endcase
      top = (line >= VISIBLE_ROWS - 1) ? line - (VISIBLE_ROWS - 1) : 0;
      st.cursor_row = 5'(line - top);
      st.cursor_col = 7'(col);
      st.window_top = 7'(top);
      st.read_cell  = '0;
      if (act == tcs_pkg::ACT_READ && vrow < VISIBLE_ROWS && vcol < COLUMNS &&
          top + vrow < STORE_ROWS)
        st.read_cell = cells[(top + vrow) * COLUMNS + vcol];
      pending_status.push_back(st);
    endfunction

    task check_status(console_status_t got);
      console_status_t want;
      results++;
      if (pending_status.size() == 0) begin
        flag("result word with no accepted word waiting for it");
        return;
      end
      want = pending_status.pop_front();
      if (got.cursor_row !== want.cursor_row)
        flag($sformatf("cursor_row %0d, expected %0d", got.cursor_row, want.cursor_row));
      if (got.cursor_col !== want.cursor_col)
        flag($sformatf("cursor_col %0d, expected %0d", got.cursor_col, want.cursor_col));
      if (got.window_top !== want.window_top)
        flag($sformatf("window_top %0d, expected %0d", got.window_top, want.window_top));
      if (got.read_cell !== want.read_cell)
        flag($sformatf("read_cell %h, expected %h", got.read_cell, want.read_cell));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = tcs_pkg::ACT_READ;
  logic [15:0] char_cell_i = '0;
  logic [4:0]  view_row_i = '0;
  logic [6:0]  view_col_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [4:0]  cursor_row_o;
  logic [6:0]  cursor_col_o;
  logic [6:0]  window_top_o;
  logic [15:0] read_cell_o;

  console_tracker tracker = new();
  int             cycles = 0;
  int             words_sent = 0;
  int             reads_sent = 0;
  int             erases_sent = 0;
  int             clears_sent = 0;
  int             blank_writes = 0;
  bit             allow_gaps = 1'b1;

  text_console_scrollback_unit #(
    .COLUMNS      (COLUMNS),
    .STORE_ROWS   (STORE_ROWS),
    .VISIBLE_ROWS (VISIBLE_ROWS),
    .TAB_STOP     (TAB_STOP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .char_cell_i  (char_cell_i),
    .view_row_i   (view_row_i),
    .view_col_i   (view_col_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .window_top_o (window_top_o),
    .read_cell_o  (read_cell_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still due.", cycles,
               tracker.pending_status.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The unit cannot be held off, so every strobed result is checked at its edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      tracker.check_status({cursor_row_o, cursor_col_o, window_top_o, read_cell_o});
  end

  // Leaves start high on return so that the next word can follow without a gap.
  task automatic send_word(tcs_pkg::action_e act, logic [15:0] char_cell,
                           logic [4:0] vrow, logic [6:0] vcol);
    if (allow_gaps && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= act;
    char_cell_i <= char_cell;
    view_row_i  <= vrow;
    view_col_i  <= vcol;
    do @(posedge clk_i); while (busy);
    tracker.note_word(act, char_cell, vrow, vcol);
    words_sent++;
    if (act == tcs_pkg::ACT_READ) reads_sent++;
    if (act == tcs_pkg::ACT_ERASE) erases_sent++;
    if (act == tcs_pkg::ACT_CLEAR) clears_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk_i);
  endtask

  // A row fill may still run after the last result, so let the unit settle.
  task automatic write_blank(logic [15:0] value);
    drain_results();
    do @(posedge clk_i); while (busy);
    repeat (COLUMNS + 8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.blank = value;
    blank_writes++;
  endtask

  task automatic send_random_word(int newline_pct);
    int          pick;
    logic [15:0] char_cell;
    logic [4:0]  vrow;
    logic [6:0]  vcol;
    pick = $urandom_range(0, 999);
    char_cell = 16'($urandom);
    vrow = 5'($urandom);
    vcol = 7'($urandom);
    if (pick < 3) begin
      send_word(tcs_pkg::ACT_CLEAR, char_cell, vrow, vcol);
    end else if (pick < 20) begin
      // Erase runs walk the cursor back across rows and pull the window up.
      repeat ($urandom_range(5, 100))
        send_word(tcs_pkg::ACT_ERASE, 16'($urandom), vrow, vcol);
    end else if (pick < 90) begin
      send_word(tcs_pkg::ACT_ERASE, char_cell, vrow, vcol);
    end else if (pick < 300) begin
      if ($urandom_range(0, 9) != 0) begin
        vrow = 5'($urandom_range(0, VISIBLE_ROWS - 1));
        vcol = 7'($urandom_range(0, COLUMNS - 1));
      end
      send_word(tcs_pkg::ACT_READ, char_cell, vrow, vcol);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) char_cell[7:0] = tcs_pkg::CH_NEWLINE;
      else if (pick < newline_pct + 10) char_cell[7:0] = tcs_pkg::CH_TAB;
      else if (pick < newline_pct + 15) char_cell[7:0] = tcs_pkg::CH_BKSP;
      send_word(tcs_pkg::ACT_PUT, char_cell, vrow, vcol);
    end
  endtask

  initial begin
    logic [15:0] blank_plan [PHASES];
    int          newline_plan [PHASES];
    int          phase_start;

    blank_plan   = '{16'($urandom), 16'h0000, 16'hFFFF, 16'($urandom),
                     tcs_pkg::BLANK_RESET};
    newline_plan = '{10, 40, 15, 60, 25};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words on the reset blank cell.
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_ERASE, 16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'hFFFF, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h1F41, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h0708, 5'd31, 7'd127);
    send_word(tcs_pkg::ACT_PUT,   16'hFF08, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h0008, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h0008, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'hF00A, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_ERASE, 16'hFFFF, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h2E58, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_ERASE, 16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'hFF09, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_PUT,   16'h0009, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd24, 7'd79);
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd25, 7'd0);
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd0,  7'd80);
    send_word(tcs_pkg::ACT_READ,  16'hFFFF, 5'd31, 7'd127);
    send_word(tcs_pkg::ACT_CLEAR, 16'h0000, 5'd0,  7'd0);
    send_word(tcs_pkg::ACT_READ,  16'h0000, 5'd0,  7'd0);

    for (int p = 0; p < PHASES; p++) begin
      write_blank(blank_plan[p]);
      allow_gaps = (p != 2);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        send_random_word(newline_plan[p]);
        if (p == 1 && words_sent - phase_start == PHASE_WORDS / 2) drain_results();
      end
    end

    drain_results();
    repeat (2 * COLUMNS + 20) @(posedge clk_i);
    $display("Ran %0d words: %0d reads, %0d erases, %0d clears, %0d blank cell writes.",
             words_sent, reads_sent, erases_sent, clears_sent, blank_writes);
    $display("Checked %0d results over %0d scrolls; deepest store row %0d.",
             tracker.results, tracker.scrolls, tracker.deepest_line);
    if (tracker.mismatches == 0 && tracker.pending_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing.", tracker.mismatches,
               tracker.pending_status.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
